/* sv/assert_macros.svh */
// Assertion macros used by the splitter top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked while out of reset.
`define ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("splitter assertion failed");

// Next-cycle implication, checked while out of reset.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("splitter assertion failed");

`endif

/* sv/ausplit_pkg.sv */
// Types, constants and classification logic for the access unit splitter.
`timescale 1ns / 1ps
package ausplit_pkg;

  localparam int LEN_W = 24;
  localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};
  localparam logic [LEN_W-1:0] CAND_LAG = LEN_W'(4);

  localparam logic [31:0] START_CODE4 = 32'h0000_0001;
  localparam logic [23:0] START_CODE3 = 24'h00_0001;
  localparam logic [2:0]  HDR_FOUR    = 3'd4;
  localparam logic [2:0]  HDR_THREE   = 3'd3;
  localparam logic [1:0]  SKIP_AFTER  = 2'd3;

  localparam logic [4:0] NAL_NONIDR = 5'd1;
  localparam logic [4:0] NAL_IDR    = 5'd5;
  localparam logic [4:0] NAL_SPS    = 5'd7;
  localparam logic [4:0] NAL_PPS    = 5'd8;

  localparam int OQ_DEPTH = 4;
  localparam int OQ_AW    = 2;
  localparam int OQ_CW    = 3;

  typedef struct packed {
    logic [1:0]       skip;
    logic [1:0]       nonidr;
    logic [1:0]       idr;
    logic [1:0]       sps_cnt;
    logic [1:0]       pps_cnt;
    logic [LEN_W-1:0] sps_start;
    logic [LEN_W-1:0] sps_span;
    logic             sps_flag;
  } seg_t;

  typedef struct packed {
    seg_t seg;
    logic cut;
  } class_t;

  typedef struct packed {
    logic [LEN_W-1:0] segment_length;
    logic             sps_seen;
    logic [LEN_W-1:0] sps_offset;
    logic [LEN_W-1:0] sps_length;
    logic             final_segment;
  } result_t;

  // Results handed from the core to the output queue in one cycle.
  typedef struct packed {
    logic [1:0] n;
    result_t    r0;
    result_t    r1;
  } push_t;

  function automatic logic [1:0] cnt_inc(input logic [1:0] c);
    return (c == 2'd3) ? c : c + 2'd1;
  endfunction

  // Count one start code; cut is set when it opens a new access unit.
  function automatic class_t classify(input seg_t s, input logic [LEN_W-1:0] cp,
                                      input logic [2:0] hdr, input logic [4:0] nal);
    class_t r;
    r.seg = s;
    r.cut = 1'b0;
    case (nal)
      NAL_NONIDR: begin
        r.seg.nonidr = cnt_inc(s.nonidr);
        r.cut = (r.seg.nonidr == 2'd1 && s.idr == 2'd1) || r.seg.nonidr == 2'd2;
      end
      NAL_IDR: begin
        r.seg.idr = cnt_inc(s.idr);
        r.cut = (r.seg.idr == 2'd1 && s.nonidr == 2'd1) || r.seg.idr == 2'd2;
      end
      NAL_SPS: begin
        r.seg.sps_flag  = 1'b1;
        r.seg.sps_start = cp + LEN_W'(hdr);
        r.seg.sps_cnt   = cnt_inc(s.sps_cnt);
        r.cut = r.seg.sps_cnt == 2'd1 && (s.nonidr == 2'd1 || s.idr == 2'd1);
      end
      NAL_PPS: begin
        r.seg.pps_cnt = cnt_inc(s.pps_cnt);
        if (r.seg.pps_cnt == 2'd1 && s.sps_cnt == 2'd1) begin
          r.seg.sps_span = (cp >= s.sps_start) ? cp - s.sps_start : '0;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic result_t make_result(input seg_t s, input logic [LEN_W-1:0] len,
                                          input logic fin);
    result_t r;
    r.segment_length = len;
    r.sps_seen       = s.sps_flag;
    r.sps_offset     = s.sps_flag ? s.sps_start : '0;
    r.sps_length     = s.sps_span;
    r.final_segment  = fin;
    return r;
  endfunction

endpackage

/* sv/ausplit_in_if.sv */
// Byte input channel of the access unit splitter.
`timescale 1ns / 1ps
interface ausplit_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

/* sv/ausplit_out_if.sv */
// Segment result channel of the access unit splitter.
`timescale 1ns / 1ps
interface ausplit_out_if
  import ausplit_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [LEN_W-1:0] segment_length;
  logic             sps_seen;
  logic [LEN_W-1:0] sps_offset;
  logic [LEN_W-1:0] sps_length;
  logic             final_segment;

  modport source (output valid, output segment_length, output sps_seen, output sps_offset,
                  output sps_length, output final_segment, input ready);
  modport sink   (input valid, input segment_length, input sps_seen, input sps_offset,
                  input sps_length, input final_segment, output ready);
endinterface

/* sv/ausplit_core.sv */
// Start code detection, NAL counting and segment cut logic.
`timescale 1ns / 1ps
module ausplit_core
  import ausplit_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_fire,
  input  logic [7:0] data_byte,
  input  logic       last_byte,
  output push_t      push
);

  logic [31:0]      hist_r, hist_nxt;
  logic [LEN_W-1:0] pos_r, pos_nxt;
  seg_t             seg_r, seg_nxt;

  logic             four, three, cut;
  logic [2:0]       hdr;
  logic [4:0]       nal;
  logic [LEN_W-1:0] cp, pos_a, pos_inc;
  class_t           cls_old, cls_new;
  seg_t             seg_a;
  result_t          cut_res, fin_res;

  always_comb begin
    four    = hist_r == START_CODE4;
    three   = !four && hist_r[31:8] == START_CODE3;
    hdr     = four ? HDR_FOUR : HDR_THREE;
    nal     = four ? data_byte[4:0] : hist_r[4:0];
    cp      = pos_r - CAND_LAG;
    cls_old = classify(seg_r, cp, hdr, nal);
    // after a cut the start code is counted again at the head of the new segment
    cls_new = classify('0, '0, hdr, nal);
    cut_res = make_result(cls_old.seg, cp, 1'b0);

    seg_a = seg_r;
    pos_a = pos_r;
    cut   = 1'b0;
    if (pos_r >= CAND_LAG) begin
      if (seg_r.skip != 2'd0) begin
        seg_a.skip = seg_r.skip - 2'd1;
      end else if (four || three) begin
        if (cls_old.cut) begin
          seg_a = cls_new.seg;
          pos_a = CAND_LAG;
          cut   = 1'b1;
        end else begin
          seg_a = cls_old.seg;
        end
        seg_a.skip = SKIP_AFTER;
      end
    end

    pos_inc = (pos_a == LEN_MAX) ? pos_a : pos_a + LEN_W'(1);
    fin_res = make_result(seg_a, pos_inc, 1'b1);

    push    = '0;
    push.r0 = cut ? cut_res : fin_res;
    push.r1 = fin_res;
    if (in_fire) begin
      push.n = {1'b0, cut} + {1'b0, last_byte};
    end

    hist_nxt = hist_r;
    pos_nxt  = pos_r;
    seg_nxt  = seg_r;
    if (in_fire) begin
      if (last_byte) begin
        hist_nxt = '0;
        pos_nxt  = '0;
        seg_nxt  = '0;
      end else begin
        hist_nxt = {hist_r[23:0], data_byte};
        pos_nxt  = pos_inc;
        seg_nxt  = seg_a;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_r <= '0;
      pos_r  <= '0;
      seg_r  <= '0;
    end else begin
      hist_r <= hist_nxt;
      pos_r  <= pos_nxt;
      seg_r  <= seg_nxt;
    end
  end

endmodule

/* sv/ausplit_oq.sv */
// Output queue: takes up to two results a cycle, hands out one per transaction.
`timescale 1ns / 1ps
module ausplit_oq
  import ausplit_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  push_t                push,
  output logic                 room,
  ausplit_out_if.source        out_ch
);

  result_t          q_r [OQ_DEPTH];
  logic [OQ_AW-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [OQ_CW-1:0] cnt_r, cnt_nxt;
  logic             pop;
  result_t          head;

  assign head   = q_r[rd_ptr_r];
  assign pop    = out_ch.valid & out_ch.ready;
  // keep space for a cut and a final result from the next byte
  assign room   = cnt_r <= OQ_CW'(OQ_DEPTH - 2);

  assign out_ch.valid          = cnt_r != '0;
  assign out_ch.segment_length = head.segment_length;
  assign out_ch.sps_seen       = head.sps_seen;
  assign out_ch.sps_offset     = head.sps_offset;
  assign out_ch.sps_length     = head.sps_length;
  assign out_ch.final_segment  = head.final_segment;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + OQ_AW'(push.n);
    rd_ptr_nxt = rd_ptr_r + OQ_AW'(pop);
    cnt_nxt    = cnt_r + OQ_CW'(push.n) - OQ_CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) begin
      q_r[wr_ptr_r] <= push.r0;
    end
    if (push.n == 2'd2) begin
      q_r[wr_ptr_r + OQ_AW'(1)] <= push.r1;
    end
  end

endmodule

/* sv/annexb_access_unit_splitter.sv */
// Top level of the Annex B access unit splitter.
//
// in_ch takes one stream byte per transaction, with last_byte marking the end of
// a buffer. out_ch gives one segment descriptor per transaction: length, SPS
// presence, SPS payload offset, SPS length up to the first PPS, final flag.
// A start code is judged four bytes after its first byte, so a cut descriptor
// appears when the fifth byte from that start code is taken. A byte may yield a
// cut descriptor, a final descriptor, or both (cut first).
// Throughput: one byte per cycle while the output queue has room. A descriptor is
// written into the queue at the edge that takes its byte, so out_ch.valid is high in
// the cycle after; the state update happens at that same edge.
// A four-entry output queue holds descriptors; in_ch.ready drops while it holds
// three or more, so a stalled receiver backs up into the byte stream after at
// most four descriptors. Descriptors are never dropped.
// Synchronous reset (rst_n low) clears the byte history, segment counters and
// queue; no clearing pass is needed. After a last_byte all segment state
// returns to its reset value.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module annexb_access_unit_splitter
  import ausplit_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  ausplit_in_if.sink    in_ch,
  ausplit_out_if.source out_ch
);

  push_t push;
  logic  room;
  logic  in_fire;

  assign in_ch.ready = room;
  assign in_fire     = in_ch.valid & in_ch.ready;

  ausplit_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_fire   (in_fire),
    .data_byte (in_ch.data_byte),
    .last_byte (in_ch.last_byte),
    .push      (push)
  );

  ausplit_oq u_oq (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .room   (room),
    .out_ch (out_ch)
  );

  `ASSERT_IMPLIES(a_last_pushes, in_fire && in_ch.last_byte, push.n != 2'd0)
  `ASSERT_IMPLIES(a_idle_no_push, !in_fire, push.n == 2'd0)
  `ASSERT_IMPLIES(a_cut_before_final, push.n == 2'd2,
                  !push.r0.final_segment && push.r1.final_segment)
  `ASSERT_NEXT(a_final_visible, in_fire && in_ch.last_byte, out_ch.valid)

endmodule

/* tb/sv/annexb_access_unit_splitter_tb.sv */
// Self-checking testbench for the Annex B access unit splitter with a reference scoreboard.
`timescale 1ns / 1ps
module annexb_access_unit_splitter_tb;
  import ausplit_pkg::*;

  // Tracks segment state per accepted byte and holds the descriptors still due.
  class au_scoreboard;
    result_t pending[$];
    int mismatches;
    logic [31:0] history;
    logic [LEN_W-1:0] position;
    logic [LEN_W-1:0] sps_start;
    logic [LEN_W-1:0] sps_span;
    logic [1:0] skip;
    logic [1:0] nonidr_cnt;
    logic [1:0] idr_cnt;
    logic [1:0] sps_cnt;
    logic [1:0] pps_cnt;
    logic sps_flag;

    function new();
      mismatches = 0;
      history = '0;
      clear_segment();
    endfunction

    function logic [LEN_W-1:0] sat_add(logic [LEN_W-1:0] a, logic [LEN_W-1:0] b);
      logic [LEN_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[LEN_W] ? LEN_MAX : s[LEN_W-1:0];
    endfunction

    function logic [1:0] bump(logic [1:0] c);
      return (c == 2'd3) ? c : c + 2'd1;
    endfunction

    function void clear_segment();
      position = '0;
      skip = '0;
      nonidr_cnt = '0;
      idr_cnt = '0;
      sps_cnt = '0;
      pps_cnt = '0;
      sps_start = '0;
      sps_span = '0;
      sps_flag = 1'b0;
    endfunction

    // Count one start code at candidate cp; return 1 when it opens a new access unit.
    function bit count_nal(logic [LEN_W-1:0] cp, logic [2:0] hdr, logic [4:0] nal);
      bit cut;
      cut = 1'b0;
      case (nal)
        NAL_NONIDR: begin
          nonidr_cnt = bump(nonidr_cnt);
          cut = (nonidr_cnt == 2'd1 && idr_cnt == 2'd1) || nonidr_cnt == 2'd2;
        end
        NAL_IDR: begin
          idr_cnt = bump(idr_cnt);
          cut = (idr_cnt == 2'd1 && nonidr_cnt == 2'd1) || idr_cnt == 2'd2;
        end
        NAL_SPS: begin
          sps_flag = 1'b1;
          sps_start = sat_add(cp, LEN_W'(hdr));
          sps_cnt = bump(sps_cnt);
          cut = sps_cnt == 2'd1 && (nonidr_cnt == 2'd1 || idr_cnt == 2'd1);
        end
        NAL_PPS: begin
          pps_cnt = bump(pps_cnt);
          if (pps_cnt == 2'd1 && sps_cnt == 2'd1) begin
            sps_span = (cp >= sps_start) ? cp - sps_start : '0;
          end
        end
        default: ;
      endcase
      return cut;
    endfunction

    function void push_result(logic [LEN_W-1:0] len, logic fin);
      result_t r;
      r.segment_length = len;
      r.sps_seen = sps_flag;
      r.sps_offset = sps_flag ? sps_start : '0;
      r.sps_length = sps_span;
      r.final_segment = fin;
      pending.push_back(r);
    endfunction

    function void note_byte(logic [7:0] b, logic last);
      logic [LEN_W-1:0] cp;
      logic [2:0] hdr;
      logic [4:0] nal;
      logic four;
      logic three;
      if (position >= CAND_LAG) begin
        if (skip != 2'd0) begin
          skip = skip - 2'd1;
        end else begin
          cp = position - CAND_LAG;
          four = history == START_CODE4;
          three = !four && history[31:8] == START_CODE3;
          if (four || three) begin
            hdr = four ? HDR_FOUR : HDR_THREE;
            nal = four ? b[4:0] : history[4:0];
            if (count_nal(cp, hdr, nal)) begin
              push_result(cp, 1'b0);
              clear_segment();
              // the cutting start code opens the new segment and counts again there
              position = CAND_LAG;
              void'(count_nal('0, hdr, nal));
            end
            skip = SKIP_AFTER;
          end
        end
      end
      history = {history[23:0], b};
      position = sat_add(position, LEN_W'(1));
      if (last) begin
        push_result(position, 1'b1);
        history = '0;
        clear_segment();
      end
    endfunction

    function void check(result_t got);
      result_t want;
      if (pending.size() == 0) begin
        if (mismatches < 10) begin
          $display("[%0t] unexpected descriptor: len %0d sps %0b off %0d slen %0d fin %0b",
                   $realtime, got.segment_length, got.sps_seen, got.sps_offset,
                   got.sps_length, got.final_segment);
        end
        mismatches++;
        return;
      end
      want = pending.pop_front();
      if (got.segment_length !== want.segment_length || got.sps_seen !== want.sps_seen ||
          got.sps_offset !== want.sps_offset || got.sps_length !== want.sps_length ||
          got.final_segment !== want.final_segment) begin
        if (mismatches < 10) begin
          $display("[%0t] descriptor mismatch:", $realtime);
          $display("  expected len %0d sps %0b off %0d slen %0d fin %0b",
                   want.segment_length, want.sps_seen, want.sps_offset,
                   want.sps_length, want.final_segment);
          $display("  actual   len %0d sps %0b off %0d slen %0d fin %0b",
                   got.segment_length, got.sps_seen, got.sps_offset,
                   got.sps_length, got.final_segment);
        end
        mismatches++;
      end
    endfunction
  endclass

  localparam int BYTE_TARGET = 620;
  localparam int RX_HOLD = 150;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  ausplit_in_if in_if();
  ausplit_out_if out_if();

  annexb_access_unit_splitter u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  au_scoreboard sb = new();
  int rx_hold_cycles = 0;
  int tx_burst = 0;
  int rx_burst = 0;
  int bytes_sent = 0;
  logic [7:0] au_bytes[$];

  always #5 clk = ~clk;

  // Random idle gap before each transfer, with occasional stretches of none.
  function automatic int draw_gap(inout int burst);
    if (burst > 0) begin
      burst--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) begin
      burst = $urandom_range(8, 40);
      return 0;
    end
    return $urandom_range(0, 6);
  endfunction

  task automatic send_byte(logic [7:0] d, logic l);
    int gap;
    gap = draw_gap(tx_burst);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.data_byte <= d;
    in_if.last_byte <= l;
    do @(posedge clk); while (!(in_if.valid && in_if.ready));
    sb.note_byte(d, l);
    bytes_sent++;
    @(negedge clk);
  endtask

  // Send the staged buffer, marking its final byte.
  task automatic flush_bytes();
    logic [7:0] d;
    while (au_bytes.size() > 0) begin
      d = au_bytes.pop_front();
      send_byte(d, au_bytes.size() == 0);
    end
  endtask

  task automatic add_start_code(bit four, logic [7:0] hdr);
    if (four) au_bytes.push_back(8'h00);
    au_bytes.push_back(8'h00);
    au_bytes.push_back(8'h00);
    au_bytes.push_back(8'h01);
    au_bytes.push_back(hdr);
  endtask

  task automatic add_random_au();
    int nals;
    int plen;
    logic [4:0] nal;
    nals = $urandom_range(1, 8);
    repeat (nals) begin
      case ($urandom_range(0, 9))
        0, 1, 2: nal = NAL_NONIDR;
        3, 4:    nal = NAL_IDR;
        5, 6:    nal = NAL_SPS;
        7, 8:    nal = NAL_PPS;
        default: nal = 5'($urandom_range(0, 31));
      endcase
      add_start_code(1'($urandom_range(0, 1)), {3'($urandom_range(0, 7)), nal});
      plen = $urandom_range(0, 6);
      repeat (plen) begin
        au_bytes.push_back(($urandom_range(0, 9) == 0) ? 8'h00 : 8'($urandom_range(1, 255)));
      end
    end
  endtask

  task automatic wait_drained();
    in_if.valid <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
  endtask

  // Receiver: random ready gaps, plus one long hold on request.
  initial begin : rx_side
    int gap;
    result_t got;
    out_if.ready <= 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      gap = draw_gap(rx_burst);
      if (rx_hold_cycles > 0) begin
        gap = rx_hold_cycles;
        rx_hold_cycles = 0;
      end
      if (gap > 0) begin
        out_if.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk); while (!(out_if.valid && out_if.ready));
      got.segment_length = out_if.segment_length;
      got.sps_seen = out_if.sps_seen;
      got.sps_offset = out_if.sps_offset;
      got.sps_length = out_if.sps_length;
      got.final_segment = out_if.final_segment;
      sb.check(got);
      @(negedge clk);
    end
  end

  initial begin
    #2_000_000;
    $display("annexb_access_unit_splitter_tb failed");
    $finish;
  end

  initial begin : tx_side
    int kind;
    int drop;
    in_if.valid <= 1'b0;
    in_if.data_byte <= 8'h00;
    in_if.last_byte <= 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Short buffer: too few bytes for any candidate to be judged.
    au_bytes = '{8'h00, 8'h00, 8'h01, 8'hFF};
    flush_bytes();
    // SPS, PPS on a three-byte code, IDR, then a non-IDR slice whose header is
    // the final byte, so the cut and the remainder leave on the same byte.
    add_start_code(1'b1, 8'h67);
    au_bytes.push_back(8'hAA);
    add_start_code(1'b0, 8'h68);
    add_start_code(1'b1, 8'h65);
    add_start_code(1'b1, 8'h41);
    flush_bytes();

    for (int round = 0; bytes_sent < BYTE_TARGET; round++) begin
      if (round == 6) begin
        // Pause until every descriptor is out, then stall the receiver and fill the block.
        wait_drained();
        rx_hold_cycles = RX_HOLD;
        repeat (15) begin
          au_bytes.push_back(8'($urandom_range(0, 255)));
          au_bytes.push_back(8'($urandom_range(0, 255)));
          flush_bytes();
        end
      end
      kind = $urandom_range(0, 19);
      if (kind < 14) begin
        add_random_au();
      end else if (kind < 17) begin
        repeat ($urandom_range(1, 12)) begin
          case ($urandom_range(0, 3))
            0, 1:    au_bytes.push_back(8'h00);
            2:       au_bytes.push_back(8'h01);
            default: au_bytes.push_back(8'($urandom_range(0, 255)));
          endcase
        end
      end else begin
        // Broken stream: truncate or corrupt a well-formed one.
        add_random_au();
        if ($urandom_range(0, 1) == 0) begin
          drop = $urandom_range(1, 4);
          while (drop > 0 && au_bytes.size() > 1) begin
            void'(au_bytes.pop_back());
            drop--;
          end
        end else begin
          au_bytes[$urandom_range(0, au_bytes.size() - 1)] = 8'($urandom_range(0, 255));
        end
      end
      flush_bytes();
    end

    wait_drained();
    repeat (10) @(negedge clk);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("annexb_access_unit_splitter_tb passed");
    end else begin
      $display("annexb_access_unit_splitter_tb failed");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+sv
sv/ausplit_pkg.sv
sv/ausplit_in_if.sv
sv/ausplit_out_if.sv
sv/ausplit_core.sv
sv/ausplit_oq.sv
sv/annexb_access_unit_splitter.sv
tb/sv/annexb_access_unit_splitter_tb.sv
